// ===== design/flat_inner_product_topk_search_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the inner-product top-k search unit
// Clocked, reset-qualified property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef FLAT_INNER_PRODUCT_TOPK_SEARCH_UNIT_DEFINES_SVH
`define FLAT_INNER_PRODUCT_TOPK_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define FIPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fips: same-cycle check failed");

// next-cycle implication
`define FIPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fips: next-cycle check failed");

`endif

// ===== design/fips_pkg.sv =====
// ---------------------------------------------------------------------------
// fips_pkg
// Shared sizes, codes and types of the inner-product top-k search unit.
// ---------------------------------------------------------------------------
`default_nettype none

package fips_pkg;

  // store geometry
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned MAX_LENGTH  = 256;
  localparam int unsigned MAX_TOP     = 16;
  localparam int unsigned ELEM_W      = 16;

  localparam int unsigned ENTRY_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned COUNT_W  = ENTRY_W + 1;
  localparam int unsigned POS_W    = $clog2(MAX_LENGTH);
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned TOP_W    = $clog2(MAX_TOP);
  localparam int unsigned TOPK_W   = 5;
  localparam int unsigned STORE_AW = ENTRY_W + POS_W;

  // arithmetic widths: exact sum of MAX_LENGTH products plus sign
  localparam int unsigned PROD_W  = 2 * ELEM_W;
  localparam int unsigned ACC_W   = PROD_W + POS_W;
  localparam int unsigned SCORE_W = 38;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned RANK_W  = 4;

  // Q8.30 clamp bound, 2^36
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 38'sh10_0000_0000;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = LEN_W;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_K         = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b1;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // tag that travels with each element pair through the dot-product pipe
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [ENTRY_W-1:0] entry;
  } scan_tag_t;

endpackage

`default_nettype wire

// ===== design/flat_inner_product_topk_search_unit.sv =====
// ---------------------------------------------------------------------------
// flat_inner_product_topk_search_unit
// Flat vector store with brute-force top-k inner-product search.
// ---------------------------------------------------------------------------
// Load, query and clear requests are taken one per cycle while the unit is
// idle. The last query element starts a scan (none when no result is due)
// that reads one stored element per cycle from the vector memory into a
// single 16x16 multiply-accumulate; the scores feed the top-k list, which is
// then read out result by result, waiting while the output stalls;
// input ready stays low for that whole time and returns with the last
// result. Results come out best first, ties going to the lower entry index.
// Memories need no clearing pass after reset.
`default_nettype none

module flat_inner_product_topk_search_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [79:0]                          s_axis_tdata_i,  // element_value, entry_id
  input  logic [fips_pkg::OP_W-1:0]            s_axis_tuser_i,  // operation
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [111:0]                         m_axis_tdata_o,  // result_id, score, rank, pad
  output logic                                 m_axis_tlast_o,  // last_result
  // register writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fips_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fips_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import fips_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_OUT_RD = 3'd3;
  localparam logic [2:0] ST_OUT_LD = 3'd4;

  // last drain count, after which the list holds the final entry
  localparam logic [1:0] DRAIN_LAST = 2'd2;
  localparam int unsigned OUT_PAD = 112 - ID_W - SCORE_W - RANK_W;

  // memories
  logic [ELEM_W-1:0] vec_mem  [MAX_ENTRIES*MAX_LENGTH];
  logic [ID_W-1:0]   id_mem   [MAX_ENTRIES];
  logic [ELEM_W-1:0] qbuf_mem [MAX_LENGTH];

  logic [2:0]          state_q, state_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [POS_W-1:0]    load_pos_q, load_pos_d;
  logic [POS_W-1:0]    qry_pos_q, qry_pos_d;
  logic [TOPK_W-1:0]   topk_q;
  logic [LEN_W-1:0]    vlen_q;
  logic [ENTRY_W-1:0]  scan_e_q, scan_e_d;
  logic [POS_W-1:0]    scan_i_q, scan_i_d;
  logic [1:0]          drain_q, drain_d;
  logic [TOPK_W-1:0]   k_q, k_d;
  logic [TOP_W-1:0]    out_idx_q, out_idx_d;

  logic                in_acc;
  logic [OP_W-1:0]     in_op;
  logic [ELEM_W-1:0]   in_elem;
  logic [ID_W-1:0]     in_id;
  logic [POS_W-1:0]    last_pos;
  logic [TOPK_W-1:0]   top_act;
  logic [TOPK_W-1:0]   k_start;
  logic [POS_W-1:0]    load_p;
  logic [POS_W-1:0]    qry_p;
  logic                store_full;

  logic                vec_we, id_we, qbuf_we, issue, id_re, list_start, out_load;
  scan_tag_t           tag_d, tag_q;
  logic [ELEM_W-1:0]   vec_rd_q, qry_rd_q;
  logic [ID_W-1:0]     id_rd_q;

  logic                score_valid;
  logic signed [SCORE_W-1:0] score;
  logic [ENTRY_W-1:0]  score_entry;
  logic signed [SCORE_W-1:0] list_score;
  logic [ENTRY_W-1:0]  list_entry;

  logic                m_valid_q;
  logic [ID_W-1:0]     m_id_q;
  logic [SCORE_W-1:0]  m_score_q;
  logic [RANK_W-1:0]   m_rank_q;
  logic                m_last_q;

  // request fields
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op   = s_axis_tuser_i;
  assign in_elem = s_axis_tdata_i[ELEM_W-1:0];
  assign in_id   = s_axis_tdata_i[ELEM_W +: ID_W];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;

  // effective length and result count
  always_comb begin
    if (vlen_q == '0) begin
      last_pos = '0;
    end else if (vlen_q > LEN_W'(MAX_LENGTH)) begin
      last_pos = POS_W'(MAX_LENGTH - 1);
    end else begin
      last_pos = POS_W'(vlen_q - 1'b1);
    end
    top_act    = (topk_q > TOPK_W'(MAX_TOP)) ? TOPK_W'(MAX_TOP) : topk_q;
    k_start    = (COUNT_W'(top_act) > count_q) ? TOPK_W'(count_q) : top_act;
    load_p     = (load_pos_q > last_pos) ? last_pos : load_pos_q;
    qry_p      = (qry_pos_q > last_pos) ? last_pos : qry_pos_q;
    store_full = (count_q == COUNT_W'(MAX_ENTRIES));
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    load_pos_d = load_pos_q;
    qry_pos_d  = qry_pos_q;
    scan_e_d   = scan_e_q;
    scan_i_d   = scan_i_q;
    drain_d    = drain_q;
    k_d        = k_q;
    out_idx_d  = out_idx_q;
    vec_we     = 1'b0;
    id_we      = 1'b0;
    qbuf_we    = 1'b0;
    issue      = 1'b0;
    id_re      = 1'b0;
    list_start = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_LOAD: begin
              if (!store_full) begin
                vec_we = 1'b1;
                if (load_p == last_pos) begin
                  id_we      = 1'b1;
                  count_d    = count_q + 1'b1;
                  load_pos_d = '0;
                end else begin
                  load_pos_d = load_p + 1'b1;
                end
              end
            end
            OP_QUERY: begin
              qbuf_we = 1'b1;
              if (qry_p == last_pos) begin
                qry_pos_d = '0;
                if (k_start != '0) begin
                  k_d        = k_start;
                  scan_e_d   = '0;
                  scan_i_d   = '0;
                  list_start = 1'b1;
                  state_d    = ST_SCAN;
                end
              end else begin
                qry_pos_d = qry_p + 1'b1;
              end
            end
            OP_CLEAR: begin
              count_d    = '0;
              load_pos_d = '0;
              qry_pos_d  = '0;
            end
            default: begin
              // unused code, ignored
            end
          endcase
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (scan_i_q == last_pos) begin
          scan_i_d = '0;
          scan_e_d = scan_e_q + 1'b1;
          if (scan_e_q == ENTRY_W'(count_q - 1'b1)) begin
            drain_d = '0;
            state_d = ST_DRAIN;
          end
        end else begin
          scan_i_d = scan_i_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == DRAIN_LAST) begin
          out_idx_d = '0;
          state_d   = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        id_re   = 1'b1;
        state_d = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          if (TOPK_W'(out_idx_q) == k_q - 1'b1) begin
            state_d = ST_IDLE;
          end else begin
            out_idx_d = out_idx_q + 1'b1;
            state_d   = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      load_pos_q <= '0;
      qry_pos_q  <= '0;
      scan_e_q   <= '0;
      scan_i_q   <= '0;
      drain_q    <= '0;
      k_q        <= '0;
      out_idx_q  <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      load_pos_q <= load_pos_d;
      qry_pos_q  <= qry_pos_d;
      scan_e_q   <= scan_e_d;
      scan_i_q   <= scan_i_d;
      drain_q    <= drain_d;
      k_q        <= k_d;
      out_idx_q  <= out_idx_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topk_q <= TOPK_W'(1);
      vlen_q <= LEN_W'(MAX_LENGTH);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TOP_K:         topk_q <= cfg_data_i[TOPK_W-1:0];
        REG_VECTOR_LENGTH: vlen_q <= cfg_data_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[{count_q[ENTRY_W-1:0], load_p}] <= in_elem;
    end
    if (id_we) begin
      id_mem[count_q[ENTRY_W-1:0]] <= in_id;
    end
    if (qbuf_we) begin
      qbuf_mem[qry_p] <= in_elem;
    end
  end

  // memory reads, registered
  always_ff @(posedge clk_i) begin
    if (issue) begin
      vec_rd_q <= vec_mem[{scan_e_q, scan_i_q}];
      qry_rd_q <= qbuf_mem[scan_i_q];
    end
    if (id_re) begin
      id_rd_q <= id_mem[list_entry];
    end
  end

  // tag aligned with the read data
  always_comb begin
    tag_d.valid = issue;
    tag_d.first = (scan_i_q == '0);
    tag_d.last  = (scan_i_q == last_pos);
    tag_d.entry = scan_e_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_d;
    end
  end

  fips_dot_unit u_dot (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tag_i         (tag_q),
    .vec_i         ($signed(vec_rd_q)),
    .qry_i         ($signed(qry_rd_q)),
    .score_valid_o (score_valid),
    .score_o       (score),
    .entry_o       (score_entry)
  );

  fips_topk_list u_list (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (list_start),
    .k_i         (k_q),
    .ins_valid_i (score_valid),
    .ins_score_i (score),
    .ins_entry_i (score_entry),
    .rd_idx_i    (out_idx_q),
    .rd_score_o  (list_score),
    .rd_entry_o  (list_entry)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_id_q    <= id_rd_q;
      m_score_q <= list_score;
      m_rank_q  <= out_idx_q;
      m_last_q  <= (TOPK_W'(out_idx_q) == k_q - 1'b1);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD{1'b0}}, m_rank_q, m_score_q, m_id_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire

// ===== design/fips_dot_unit.sv =====
// ---------------------------------------------------------------------------
// fips_dot_unit
// Shared multiply-accumulate: one element product per cycle, a clamped
// Q8.30 score at the end of every stored vector.
// ---------------------------------------------------------------------------
`default_nettype none

module fips_dot_unit (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  fips_pkg::scan_tag_t                      tag_i,
  input  logic signed [fips_pkg::ELEM_W-1:0]       vec_i,
  input  logic signed [fips_pkg::ELEM_W-1:0]       qry_i,
  output logic                                     score_valid_o,
  output logic signed [fips_pkg::SCORE_W-1:0]      score_o,
  output logic        [fips_pkg::ENTRY_W-1:0]      entry_o
);
  import fips_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SCORE_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX;

  scan_tag_t                  tag_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ACC_W-1:0]    acc_base;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [SCORE_W-1:0]  sat_score;
  logic                       score_valid_q;
  logic signed [SCORE_W-1:0]  score_q;
  logic        [ENTRY_W-1:0]  entry_q;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= vec_i * qry_i;
  end

  // accumulate, restart on the first element of each vector
  always_comb begin
    acc_base = tag_q.first ? '0 : acc_q;
    acc_sum  = acc_base + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (acc_sum > ACC_MAX) begin
      sat_score = SCORE_MAX;
    end else if (acc_sum < ACC_MIN) begin
      sat_score = -SCORE_MAX;
    end else begin
      sat_score = acc_sum[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_q.valid) begin
      acc_q <= acc_sum;
    end
    if (tag_q.valid && tag_q.last) begin
      score_q <= sat_score;
      entry_q <= tag_q.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_valid_q <= 1'b0;
    end else begin
      score_valid_q <= tag_q.valid && tag_q.last;
    end
  end

  assign score_valid_o = score_valid_q;
  assign score_o       = score_q;
  assign entry_o       = entry_q;

endmodule

`default_nettype wire

// ===== design/fips_topk_list.sv =====
// ---------------------------------------------------------------------------
// fips_topk_list
// Sorted list of the best scores so far; one insertion per cycle with all
// slots compared at once, ties keep the earlier entry ahead.
// ---------------------------------------------------------------------------
`default_nettype none

module fips_topk_list (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic        [fips_pkg::TOPK_W-1:0]   k_i,
  input  logic                                 ins_valid_i,
  input  logic signed [fips_pkg::SCORE_W-1:0]  ins_score_i,
  input  logic        [fips_pkg::ENTRY_W-1:0]  ins_entry_i,
  input  logic        [fips_pkg::TOP_W-1:0]    rd_idx_i,
  output logic signed [fips_pkg::SCORE_W-1:0]  rd_score_o,
  output logic        [fips_pkg::ENTRY_W-1:0]  rd_entry_o
);
  import fips_pkg::*;

  logic signed [SCORE_W-1:0] score_q [MAX_TOP];
  logic        [ENTRY_W-1:0] entry_q [MAX_TOP];
  logic        [TOPK_W-1:0]  fill_q;
  logic        [MAX_TOP-1:0] ins;
  logic        [MAX_TOP-1:0] prev_ins;

  // a slot moves when it is empty or the new score beats it
  always_comb begin
    for (int j = 0; j < MAX_TOP; j++) begin
      ins[j] = (TOPK_W'(j) >= fill_q) || (ins_score_i > score_q[j]);
    end
    prev_ins[0] = 1'b0;
    for (int j = 1; j < MAX_TOP; j++) begin
      prev_ins[j] = ins[j-1];
    end
  end

  // new value lands at the first moving slot, the ones below shift down
  always_ff @(posedge clk_i) begin
    if (ins_valid_i) begin
      if ((k_i != '0) && ins[0]) begin
        score_q[0] <= ins_score_i;
        entry_q[0] <= ins_entry_i;
      end
      for (int j = 1; j < MAX_TOP; j++) begin
        if ((TOPK_W'(j) < k_i) && ins[j]) begin
          if (!prev_ins[j]) begin
            score_q[j] <= ins_score_i;
            entry_q[j] <= ins_entry_i;
          end else begin
            score_q[j] <= score_q[j-1];
            entry_q[j] <= entry_q[j-1];
          end
        end
      end
    end
  end

  // fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (start_i) begin
      fill_q <= '0;
    end else if (ins_valid_i && (fill_q < k_i)) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  assign rd_score_o = score_q[rd_idx_i];
  assign rd_entry_o = entry_q[rd_idx_i];

endmodule

`default_nettype wire

// ===== design/fips_checker.sv =====
// ---------------------------------------------------------------------------
// fips_checker
// Port-level checks of the search unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "flat_inner_product_topk_search_unit_defines.svh"

module fips_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid_i,
  input logic                               s_axis_tready_o,
  input logic [fips_pkg::OP_W-1:0]          s_axis_tuser_i,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [111:0]                       m_axis_tdata_o,
  input logic                               m_axis_tlast_o,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o
);
  import fips_pkg::*;

  logic in_clear;
  logic out_mid;

  assign in_clear = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == OP_CLEAR);
  assign out_mid  = m_axis_tvalid_o && !m_axis_tlast_o;

  // stalled result holds
  `FIPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

  // no request taken while a query's result list is still going out
  `FIPS_ASSERT_NOW(a_busy_mid_list, out_mid, !s_axis_tready_o)

  // a clear completes in its own cycle
  `FIPS_ASSERT_NEXT(a_clear_ready, in_clear, s_axis_tready_o)

  // config port never back-pressures
  `FIPS_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind flat_inner_product_topk_search_unit fips_checker u_fips_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: flat inner-product top-k search unit
// Drives load, query and clear requests over the request stream with random
// gaps and result-side stalls. A behavioral mirror of the vector store works
// out the ranked matches of every query. Each match is checked field by field.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fips_pkg::*;

  // code outside the operation enum, must be ignored by the unit
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam longint SCORE_LIMIT = longint'(1) << 36;
  localparam int unsigned RANDOM_REQUESTS = 450;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef enum {FILL_RANDOM, FILL_NARROW, FILL_CONST} fill_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
    logic [RANK_W-1:0]  rank;
    logic               last;
  } match_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [79:0]           s_axis_tdata_i;   // element_value, entry_id
  logic [OP_W-1:0]       s_axis_tuser_i;   // operation
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [111:0]          m_axis_tdata_o;   // result_id, score, rank, pad
  logic                  m_axis_tlast_o;   // last_result
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  flat_inner_product_topk_search_unit u_dut (.*);

  // mirror of the unit's store and registers
  bit signed [ELEM_W-1:0] vector_mem [MAX_ENTRIES*MAX_LENGTH];
  bit [ID_W-1:0]          id_mem [MAX_ENTRIES];
  bit signed [ELEM_W-1:0] query_mem [MAX_LENGTH];
  int unsigned stored_count = 0;
  int unsigned load_pos = 0;
  int unsigned query_pos = 0;
  int unsigned top_k_reg = 1;
  int unsigned length_reg = 256;

  match_t expected_matches[$];
  int unsigned mismatches = 0;
  int unsigned matches_checked = 0;
  int unsigned requests_sent = 0;
  int unsigned scans_run = 0;
  bit tx_quiet = 0;
  bit rx_quiet = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("[flat_inner_product_topk_search_unit] ERROR");
    $finish;
  end

  function automatic int unsigned active_length();
    if (length_reg == 0) return 1;
    if (length_reg > MAX_LENGTH) return MAX_LENGTH;
    return length_reg;
  endfunction

  function automatic int unsigned active_top();
    return (top_k_reg > MAX_TOP) ? MAX_TOP : top_k_reg;
  endfunction

  // exact dot product, clamped to the Q8.30 range
  function automatic longint entry_score(int unsigned entry, int unsigned len);
    longint acc;
    acc = 0;
    for (int unsigned i = 0; i < len; i++)
      acc += longint'(vector_mem[entry*MAX_LENGTH + i]) * longint'(query_mem[i]);
    if (acc > SCORE_LIMIT) acc = SCORE_LIMIT;
    if (acc < -SCORE_LIMIT) acc = -SCORE_LIMIT;
    return acc;
  endfunction

  // insertion ranking over all entries; strict compare keeps lower index on ties
  function automatic void rank_matches();
    longint      best_score [MAX_TOP];
    int unsigned best_entry [MAX_TOP];
    int unsigned k, filled, pos, len;
    longint      s;
    match_t      m;
    len = active_length();
    k = active_top();
    if (k > stored_count) k = stored_count;
    filled = 0;
    scans_run++;
    if (k == 0) return;
    for (int unsigned e = 0; e < stored_count; e++) begin
      s = entry_score(e, len);
      if (filled == k && !(s > best_score[k-1])) continue;
      if (filled < k) begin
        pos = filled;
        filled++;
      end else begin
        pos = k - 1;
      end
      while (pos > 0 && s > best_score[pos-1]) begin
        best_score[pos] = best_score[pos-1];
        best_entry[pos] = best_entry[pos-1];
        pos--;
      end
      best_score[pos] = s;
      best_entry[pos] = e;
    end
    for (int unsigned i = 0; i < k; i++) begin
      m.id    = id_mem[best_entry[i]];
      m.score = best_score[i][SCORE_W-1:0];
      m.rank  = i[RANK_W-1:0];
      m.last  = (i + 1 == k);
      expected_matches.push_back(m);
    end
  endfunction

  function automatic void predict_request(logic [OP_W-1:0] op, logic [ELEM_W-1:0] elem,
                                          logic [ID_W-1:0] id);
    int unsigned len, p;
    len = active_length();
    if (op == OP_LOAD) begin
      if (stored_count < MAX_ENTRIES) begin
        p = (load_pos < len) ? load_pos : len - 1;
        vector_mem[stored_count*MAX_LENGTH + p] = elem;
        if (p + 1 >= len) begin
          id_mem[stored_count] = id;
          stored_count++;
          load_pos = 0;
        end else begin
          load_pos = p + 1;
        end
      end
    end else if (op == OP_QUERY) begin
      p = (query_pos < len) ? query_pos : len - 1;
      query_mem[p] = elem;
      if (p + 1 >= len) begin
        query_pos = 0;
        rank_matches();
      end else begin
        query_pos = p + 1;
      end
    end else if (op == OP_CLEAR) begin
      stored_count = 0;
      load_pos = 0;
      query_pos = 0;
    end
  endfunction

  function automatic logic [ID_W-1:0] random_id();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element(fill_e fill, logic [ELEM_W-1:0] value);
    if (fill == FILL_CONST) return value;
    if (fill == FILL_NARROW) return ELEM_W'(int'($urandom_range(0, 4)) - 2);
    return ELEM_W'($urandom);
  endfunction

  // one request on the input stream; valid stays high when no gap follows
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ELEM_W-1:0] elem,
                              input logic [ID_W-1:0] id);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {id, elem};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_request(op, elem, id);
    requests_sent++;
  endtask

  // n elements of one kind; the id rides on the final element
  task automatic send_vector(input logic [OP_W-1:0] op, input int unsigned n,
                             input logic [ID_W-1:0] id, input fill_e fill,
                             input logic [ELEM_W-1:0] value = '0);
    for (int unsigned i = 0; i < n; i++)
      send_request(op, pick_element(fill, value), (i + 1 == n) ? id : random_id());
  endtask

  task automatic send_clear();
    send_request(OP_CLEAR, ELEM_W'($urandom), random_id());
  endtask

  // let outstanding matches drain and any empty scan finish
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (stored_count * active_length() + SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == REG_TOP_K) top_k_reg = value & 31;
    else length_reg = value & 511;
    @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned top, input int unsigned len);
    settle();
    write_register(REG_TOP_K, CFG_DATA_W'(top));
    write_register(REG_VECTOR_LENGTH, CFG_DATA_W'(len));
  endtask

  // empty store and top_k of zero give no matches; code 3 is ignored
  task automatic test_no_match_cases();
    configure(1, 2);
    send_vector(OP_QUERY, 2, random_id(), FILL_RANDOM);
    send_request(OP_UNUSED, ELEM_W'($urandom), random_id());
    send_vector(OP_LOAD, 2, random_id(), FILL_RANDOM);
    send_vector(OP_LOAD, 2, random_id(), FILL_RANDOM);
    settle();
    write_register(REG_TOP_K, '0);
    send_vector(OP_QUERY, 2, random_id(), FILL_RANDOM);
    send_clear();
  endtask

  // field extremes, equal scores, top_k above the maximum
  task automatic test_extreme_values();
    configure(20, 3);
    send_clear();
    send_vector(OP_LOAD, 3, 64'h7fff_ffff_ffff_ffff, FILL_CONST, 16'h7fff);
    send_vector(OP_LOAD, 3, 64'h8000_0000_0000_0000, FILL_CONST, 16'h8000);
    send_vector(OP_LOAD, 3, 64'h0, FILL_CONST, 16'h0000);
    send_vector(OP_LOAD, 3, 64'hffff_ffff_ffff_ffff, FILL_CONST, 16'h7fff);
    send_vector(OP_LOAD, 3, random_id(), FILL_CONST, 16'h0001);
    send_vector(OP_LOAD, 3, random_id(), FILL_CONST, 16'hffff);
    send_request(OP_QUERY, 16'h8000, random_id());
    send_request(OP_QUERY, 16'h7fff, random_id());
    send_request(OP_QUERY, 16'hffff, random_id());
  endtask

  // length shortened mid-vector and mid-query, then raised over old data
  task automatic test_length_changes();
    configure(4, 4);
    send_clear();
    repeat (4) send_vector(OP_LOAD, 4, random_id(), FILL_RANDOM);
    send_clear();
    settle();
    write_register(REG_VECTOR_LENGTH, 9'd2);
    send_request(OP_LOAD, ELEM_W'($urandom), random_id());
    settle();
    write_register(REG_VECTOR_LENGTH, 9'd1);
    send_request(OP_LOAD, ELEM_W'($urandom), random_id());
    settle();
    write_register(REG_VECTOR_LENGTH, 9'd4);
    send_vector(OP_LOAD, 4, random_id(), FILL_RANDOM);
    send_vector(OP_QUERY, 2, random_id(), FILL_RANDOM);
    settle();
    write_register(REG_VECTOR_LENGTH, 9'd2);
    send_request(OP_QUERY, ELEM_W'($urandom), random_id());
    settle();
    write_register(REG_VECTOR_LENGTH, 9'd4);
    send_vector(OP_QUERY, 4, random_id(), FILL_RANDOM);
  endtask

  // sums past 2^36 clamp both ways; clamped ties keep index order
  task automatic test_score_saturation();
    configure(4, 65);
    send_clear();
    send_vector(OP_LOAD, 65, random_id(), FILL_CONST, 16'h8000);
    send_vector(OP_LOAD, 65, random_id(), FILL_CONST, 16'h8000);
    send_vector(OP_LOAD, 65, random_id(), FILL_CONST, 16'h7fff);
    send_vector(OP_LOAD, 65, random_id(), FILL_RANDOM);
    send_vector(OP_QUERY, 65, random_id(), FILL_CONST, 16'h8000);
  endtask

  // length 0 acts as 1, lengths past the maximum act as the maximum
  task automatic test_length_limits();
    configure(2, 0);
    send_clear();
    repeat (3) send_vector(OP_LOAD, 1, random_id(), FILL_RANDOM);
    send_vector(OP_QUERY, 1, random_id(), FILL_RANDOM);
    configure(2, $urandom_range(257, 511));
    send_clear();
    send_vector(OP_LOAD, MAX_LENGTH, random_id(), FILL_RANDOM);
    send_vector(OP_QUERY, MAX_LENGTH, random_id(), FILL_RANDOM);
  endtask

  // loads past a full store are dropped; many ties among small values
  task automatic test_store_full();
    configure(16, 1);
    send_clear();
    repeat (MAX_ENTRIES + 4) send_vector(OP_LOAD, 1, random_id(), FILL_NARROW);
    send_request(OP_QUERY, 16'h0001, random_id());
    send_clear();
    send_request(OP_QUERY, ELEM_W'($urandom), random_id());
    repeat (2) send_vector(OP_LOAD, 1, random_id(), FILL_RANDOM);
    send_request(OP_QUERY, ELEM_W'($urandom), random_id());
  endtask

  // phases of random settings; mostly whole vectors, some fragments and noise
  task automatic test_random_traffic();
    int unsigned first, len, top, units, pick;
    fill_e fill;
    first = requests_sent;
    while (requests_sent - first < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 6);
        7, 8:                len = $urandom_range(7, 16);
        default:             len = $urandom_range(17, 40);
      endcase
      top = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 31) : $urandom_range(0, 8);
      configure(top, len);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      fill = ($urandom_range(0, 2) == 0) ? FILL_NARROW : FILL_RANDOM;
      send_clear();
      units = $urandom_range(6, 14);
      repeat (units) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          if (stored_count * len >= 1200) send_clear();
          else send_vector(OP_LOAD, len, random_id(), fill);
        end else if (pick < 80) begin
          send_vector(OP_QUERY, len, random_id(), fill);
        end else if (pick < 88) begin
          send_vector(pick[0] ? OP_LOAD : OP_QUERY, $urandom_range(1, len), random_id(), fill);
        end else if (pick < 94) begin
          send_clear();
        end else begin
          send_request(OP_UNUSED, ELEM_W'($urandom), random_id());
        end
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // result side: random stall before each match
  initial begin
    int unsigned gap;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // compare each accepted match with the oldest expectation
  always @(posedge clk_i) begin
    match_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      matches_checked++;
      if (expected_matches.size() == 0) begin
        $error("unexpected match: id %h score %h", m_axis_tdata_o[63:0],
               m_axis_tdata_o[101:64]);
        mismatches++;
      end else begin
        want = expected_matches.pop_front();
        if (m_axis_tdata_o[63:0] !== want.id) begin
          $error("result_id: expected %h, got %h", want.id, m_axis_tdata_o[63:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[101:64] !== want.score) begin
          $error("score: expected %h, got %h", want.score, m_axis_tdata_o[101:64]);
          mismatches++;
        end
        if (m_axis_tdata_o[105:102] !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, m_axis_tdata_o[105:102]);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_result: expected %b, got %b", want.last, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= OP_LOAD;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= REG_TOP_K;
    cfg_data_i      <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_match_cases();
    test_extreme_values();
    test_length_changes();
    test_score_saturation();
    test_length_limits();
    test_store_full();
    test_random_traffic();

    settle();
    if (expected_matches.size() != 0) begin
      $error("%0d expected matches never arrived", expected_matches.size());
      mismatches += expected_matches.size();
    end
    $display("Run covered %0d requests and %0d scans over directed and random settings",
             requests_sent, scans_run);
    $display("Checked %0d matches, %0d field mismatches", matches_checked, mismatches);
    if (mismatches == 0) begin
      $display("[flat_inner_product_topk_search_unit] OK");
    end else begin
      $display("[flat_inner_product_topk_search_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/fips_pkg.sv
design/fips_dot_unit.sv
design/fips_topk_list.sv
design/flat_inner_product_topk_search_unit.sv
design/fips_checker.sv
tb/testbench.sv
